// ===== hw/rtl/psq_pkg.sv =====
// ----------------------------------------------------------------------------
// psq_pkg: shared types and constants of the positional sequence store
// Sizes, operation and status codes, and the structs that pass between the
// controller and the row of storage cells.
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int OUT_W    = 32;
  localparam int POS_W    = 7;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int IW       = $clog2(CAPACITY);
  localparam int XW       = (CW > POS_W) ? CW : POS_W;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_INSERT     = 4'd4,
    OP_REMOVE     = 4'd5,
    OP_READ       = 4'd6,
    OP_REVERSE    = 4'd7,
    OP_CLEAR      = 4'd8,
    OP_QUERY      = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    SQ_OK      = 2'd0,
    SQ_EMPTY   = 2'd1,
    SQ_BAD_POS = 2'd2,
    SQ_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic          ins;
    logic          del;
    logic [IW-1:0] q;
    word_t         data;
  } cell_cmd_t;

  typedef struct packed {
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] last_idx;
  } cell_view_t;

endpackage

// ===== hw/rtl/psq_cell.sv =====
// ----------------------------------------------------------------------------
// psq_cell: one storage cell of the sequence
// Holds one word and, on an insert or remove, takes the new word or the word
// of its left or right neighbor. Drives its word onto the read and last-entry
// taps when it is the selected cell.
// ----------------------------------------------------------------------------
module psq_cell
  import psq_pkg::*;
(
  input  logic          clk,
  input  logic [IW-1:0] idx,
  input  cell_cmd_t     cmd,
  input  cell_view_t    view,
  input  word_t         left_word,
  input  word_t         right_word,
  output word_t         word,
  output word_t         rd_tap,
  output word_t         last_tap
);

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (idx == cmd.q) begin
        word_nxt = cmd.data;
      end else if (idx > cmd.q) begin
        word_nxt = left_word;
      end
    end else if (cmd.del) begin
      if (idx >= cmd.q) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word     = word_r;
  assign rd_tap   = (idx == view.rd_idx)   ? word_r : '0;
  assign last_tap = (idx == view.last_idx) ? word_r : '0;

endmodule

// ===== hw/rtl/psq_ctrl.sv =====
// ----------------------------------------------------------------------------
// psq_ctrl: request sequencer of the positional sequence store
// Takes a request, decides its status and the cell to shift at, keeps the
// entry count and direction bit, and builds the result in the output register.
// ----------------------------------------------------------------------------
module psq_ctrl
  import psq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [3:0]    in_op,
  input  word_t         in_word,
  input  logic [POS_W-1:0] in_pos,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [1:0]    out_status,
  output logic [OUT_W-1:0] out_read,
  output logic [POS_W-1:0] out_count,
  output logic [OUT_W-1:0] out_front,
  output logic [OUT_W-1:0] out_back,
  output cell_cmd_t     cmd,
  output cell_view_t    view,
  input  word_t         first_word,
  input  word_t         rd_word,
  input  word_t         last_word
);

  state_t state_r, state_nxt;

  op_t              op_r;
  word_t            val_r;
  logic [POS_W-1:0] pos_r;
  status_t          status_r, status_c;
  logic [IW-1:0]    rd_idx_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             rev_r, rev_nxt;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [OUT_W-1:0] out_read_r, out_front_r, out_back_r;
  logic [POS_W-1:0] out_count_r;

  logic          accept, out_load, exec;
  logic          do_ins, do_del;
  logic [XW-1:0] q_x, rdq_x, pos_x, cnt_x;
  logic          full, empty;
  word_t         rd_val, front_w, back_w;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load  = 1'b0;
    in_tready = 1'b0;
    exec      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_EXEC: begin
        exec = 1'b1;
      end
      ST_FINISH: begin
        out_load  = !out_valid_r || out_tready;
        in_tready = out_load;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_x     = XW'(pos_r);
    cnt_x     = XW'(count_r);
    full      = cnt_x >= XW'(CAPACITY);
    empty     = (count_r == '0);
    status_c  = SQ_OK;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    q_x       = '0;
    rdq_x     = rev_r ? (cnt_x - XW'(1) - pos_x) : pos_x;
    rev_nxt   = rev_r;
    case (op_r)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_c = SQ_FULL;
        end else begin
          do_ins = 1'b1;
          q_x    = rev_r ? cnt_x : '0;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_c = SQ_FULL;
        end else begin
          do_ins = 1'b1;
          q_x    = rev_r ? '0 : cnt_x;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_c = SQ_EMPTY;
        end else begin
          do_del = 1'b1;
          q_x    = rev_r ? (cnt_x - XW'(1)) : '0;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_c = SQ_EMPTY;
        end else begin
          do_del = 1'b1;
          q_x    = rev_r ? '0 : (cnt_x - XW'(1));
        end
      end
      OP_INSERT: begin
        if (empty) begin
          status_c = SQ_EMPTY;
        end else if (pos_x > cnt_x) begin
          status_c = SQ_BAD_POS;
        end else if (full) begin
          status_c = SQ_FULL;
        end else begin
          do_ins = 1'b1;
          q_x    = rev_r ? (cnt_x - pos_x) : pos_x;
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status_c = SQ_BAD_POS;
        end else begin
          do_del = 1'b1;
          q_x    = rdq_x;
        end
      end
      OP_READ: begin
        if (empty) begin
          status_c = SQ_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_c = SQ_BAD_POS;
        end
      end
      OP_REVERSE: begin
        if (cnt_x >= XW'(2)) rev_nxt = !rev_r;
      end
      OP_CLEAR: begin
        rev_nxt = 1'b0;
      end
      default: begin
        status_c = SQ_OK;
      end
    endcase
    if (op_r == OP_CLEAR) begin
      count_nxt = '0;
    end else if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_del) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  assign cmd.ins       = exec && do_ins;
  assign cmd.del       = exec && do_del;
  assign cmd.q         = IW'(q_x);
  assign cmd.data      = val_r;
  assign view.rd_idx   = rd_idx_r;
  assign view.last_idx = IW'(count_r - CW'(1));

  always_comb begin
    rd_val = '0;
    if (op_r == OP_READ) begin
      if (status_r == SQ_OK) begin
        rd_val = rd_word;
      end else if (status_r == SQ_EMPTY) begin
        rd_val = '1;
      end
    end
    if (count_r == '0) begin
      front_w = '0;
      back_w  = '0;
    end else begin
      front_w = rev_r ? last_word : first_word;
      back_w  = rev_r ? first_word : last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        count_r <= count_nxt;
        rev_r   <= rev_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_op);
      val_r <= in_word;
      pos_r <= in_pos;
    end
    if (exec) begin
      status_r <= status_c;
      rd_idx_r <= IW'(rdq_x);
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_read_r   <= OUT_W'(rd_val);
      out_count_r  <= POS_W'(count_r);
      out_front_r  <= OUT_W'(front_w);
      out_back_r   <= OUT_W'(back_w);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_read   = out_read_r;
  assign out_count  = out_count_r;
  assign out_front  = out_front_r;
  assign out_back   = out_back_r;

endmodule

// ===== hw/rtl/positional_sequence_store_top.sv =====
// ----------------------------------------------------------------------------
// positional_sequence_store_top: bounded ordered sequence of signed words
// A request carries an operation (push or pop at either end, insert, remove
// or read at a position, reverse, clear, query) and gets exactly one result:
// status, word read, entry count, and first and last entries afterwards.
// Input channel in_*: tuser carries the operation, tdata the word and the
// position. Output channel out_*: tuser carries the status, tdata the rest.
// Storage is a row of 64 cells; an insert or remove shifts every cell past
// the target by one place, all in the same cycle.
// A request passes the EXEC state, which decides its status and shifts the
// cells, and then the FINISH state, which gathers the read and end words
// from the row into the output register. A new request is taken no earlier
// than the FINISH state of the last one, after it has shifted the cells.
// The output register frees the input side: the next request is taken while
// a result waits. If the receiver stalls longer, the finished result of the
// following request holds the block until the output register empties.
// Reset empties the sequence and clears the reversed direction; the words in
// the cells are not cleared.
// ----------------------------------------------------------------------------
module positional_sequence_store_top
  import psq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // value [31:0], position [38:32]
  input  logic [3:0]   in_tuser,   // operation [3:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // read_value, entry_count, front_value, back_value
  output logic [1:0]   out_tuser   // status [1:0]
);

  cell_cmd_t  cmd;
  cell_view_t view;
  word_t      cell_word [CAPACITY];
  word_t      rd_taps   [CAPACITY];
  word_t      last_taps [CAPACITY];
  word_t      rd_word, last_word;
  word_t      in_word;

  logic [OUT_W-1:0] o_read, o_front, o_back;
  logic [POS_W-1:0] o_count;

  assign in_word = DATA_W'($signed(in_tdata[31:0]));

  psq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_word    (in_word),
    .in_pos     (in_tdata[38:32]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_read   (o_read),
    .out_count  (o_count),
    .out_front  (o_front),
    .out_back   (o_back),
    .cmd        (cmd),
    .view       (view),
    .first_word (cell_word[0]),
    .rd_word    (rd_word),
    .last_word  (last_word)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = cmd.data;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end
    psq_cell u_cell (
      .clk        (clk),
      .idx        (IW'(i)),
      .cmd        (cmd),
      .view       (view),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .rd_tap     (rd_taps[i]),
      .last_tap   (last_taps[i])
    );
  end

  always_comb begin
    rd_word   = '0;
    last_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word   = rd_word | rd_taps[i];
      last_word = last_word | last_taps[i];
    end
  end

  assign out_tdata = {1'b0, o_back, o_front, o_count, o_read};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[38:32] <= POS_W'(CAPACITY)))
    else $error("entry count above capacity");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == SQ_EMPTY) |-> (out_tdata[38:32] == '0))
    else $error("empty status with entries present");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[38:32] == '0) |->
      (out_tdata[70:39] == '0 && out_tdata[102:71] == '0))
    else $error("end words not zero on empty sequence");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.del))
    else $error("insert and remove shift in the same cycle");

endmodule
